FILE: hw/rtl/wbps_pkg.sv
// wbps_pkg: shared widths, codes and types of the wildcard byte pattern search
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int BYTE_W            = 8;
    localparam int ADDR_W            = 16;
    localparam int WORD_W            = 16;
    localparam int LEN_W             = 7;
    localparam int ENTRY_IDX_W       = 6;
    localparam int ROLE_W            = 2;
    localparam int SLOT_W            = 2;
    localparam int COUNT_W           = 17;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int NUM_CAPTURE_WORDS = 4;

    localparam int DEF_MAX_PATTERN_LEN = 64;
    localparam int DEF_CAPTURE_SLOTS   = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 17'h1ffff;
    localparam logic [ADDR_W-1:0]  NO_ANCHOR     = 16'hffff;
    localparam logic [ADDR_W-1:0]  ORIGIN_RESET  = 16'h0100;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // capture roles, the remaining codes capture nothing
    localparam logic [ROLE_W-1:0] ROLE_LOW  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_HIGH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHORED       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ADDRESS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ORIGIN   = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ROLE_W-1:0] role;
        logic              wild;
        logic [BYTE_W-1:0] value;
    } t_entry;

    // control broadcast along the cell chain
    typedef struct packed {
        logic                   shift;
        logic                   load;
        logic [ENTRY_IDX_W-1:0] load_index;
        t_entry                 load_entry;
    } t_cell_ctl;

    typedef struct packed {
        logic                                     kind;
        logic [ADDR_W-1:0]                        match_address;
        logic [NUM_CAPTURE_WORDS-1:0][WORD_W-1:0] capture_word;
        logic                                     any_hit;
        logic                                     multiple_hits;
        logic                                     last_result;
    } t_result;

endpackage

FILE: hw/rtl/wbps_in_if.sv
// wbps_in_if: input channel of the pattern search, pattern loads and image bytes
// depends on wbps_pkg for field widths
`timescale 1ns / 1ps

interface wbps_in_if import wbps_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [BYTE_W-1:0]      entry_value;
    logic                   entry_wildcard;
    logic [ROLE_W-1:0]      capture_role;
    logic [SLOT_W-1:0]      capture_slot;
    logic [BYTE_W-1:0]      image_byte;
    logic                   image_end;

    modport source (
        output valid, func, entry_index, entry_value, entry_wildcard,
               capture_role, capture_slot, image_byte, image_end,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, entry_value, entry_wildcard,
               capture_role, capture_slot, image_byte, image_end,
        output ready
    );

endinterface

FILE: hw/rtl/wbps_out_if.sv
// wbps_out_if: result channel of the pattern search, match reports and summaries
// depends on wbps_pkg for field widths
`timescale 1ns / 1ps

interface wbps_out_if import wbps_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] match_address;
    logic [WORD_W-1:0] capture_word0;
    logic [WORD_W-1:0] capture_word1;
    logic [WORD_W-1:0] capture_word2;
    logic [WORD_W-1:0] capture_word3;
    logic              any_hit;
    logic              multiple_hits;
    logic              last_result;

    modport source (
        output valid, kind, match_address, capture_word0, capture_word1,
               capture_word2, capture_word3, any_hit, multiple_hits, last_result,
        input  ready
    );

    modport sink (
        input  valid, kind, match_address, capture_word0, capture_word1,
               capture_word2, capture_word3, any_hit, multiple_hits, last_result,
        output ready
    );

endinterface

FILE: hw/rtl/wbps_cell.sv
// wbps_cell: one position of the search chain, holds a pattern entry and a window byte
// depends on wbps_pkg (t_entry, t_cell_ctl)
`timescale 1ns / 1ps

module wbps_cell import wbps_pkg::*; #(
    parameter int POS = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_aligned,
    output logic [BYTE_W-1:0] o_byte,
    output t_entry            o_entry,
    output logic              o_eq
);

    logic [BYTE_W-1:0] r_byte;
    t_entry            r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
        if (i_ctl.load && (32'(i_ctl.load_index) == POS)) begin
            r_entry <= i_ctl.load_entry;
        end
    end

    assign o_byte  = r_byte;
    assign o_entry = r_entry;
    assign o_eq    = r_entry.wild || (r_entry.value == i_aligned);

endmodule

FILE: hw/rtl/wbps_match.sv
// wbps_match: lines the window up with the pattern, reduces the cell compares and
// picks the captured bytes; depends on wbps_pkg
`timescale 1ns / 1ps

module wbps_match import wbps_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_PATTERN_LEN,
    parameter int SLOTS   = DEF_CAPTURE_SLOTS
) (
    input  logic [BYTE_W-1:0]          i_window  [MAX_LEN],
    input  t_entry                     i_entry   [MAX_LEN],
    input  logic [MAX_LEN-1:0]         i_eq,
    input  logic [$clog2(MAX_LEN)-1:0] i_shift,
    output logic [BYTE_W-1:0]          o_aligned [MAX_LEN],
    output logic                       o_hit,
    output logic [WORD_W-1:0]          o_capture [SLOTS]
);

    localparam int IDX_W = $clog2(MAX_LEN);

    // al[0] is the window oldest-first, each level shifts by a power of two
    logic [BYTE_W-1:0]  al [IDX_W+1][MAX_LEN];
    logic [MAX_LEN-1:0] in_use;
    logic [BYTE_W-1:0]  pick [SLOTS][2];

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_rev
        assign al[0][k] = i_window[MAX_LEN-1-k];
    end

    for (genvar b = 0; b < IDX_W; b++) begin : g_lvl
        for (genvar k = 0; k < MAX_LEN; k++) begin : g_pos
            if (k + (1 << b) < MAX_LEN) begin : g_in
                assign al[b+1][k] = i_shift[b] ? al[b][k + (1 << b)] : al[b][k];
            end else begin : g_out
                assign al[b+1][k] = i_shift[b] ? '0 : al[b][k];
            end
        end
    end

    // entry i sits at i + shift < MAX_LEN exactly when i is below the length
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_use
        assign o_aligned[i] = al[IDX_W][i];
        assign in_use[i]    = (i + int'(i_shift)) < MAX_LEN;
    end

    assign o_hit = &(~in_use | i_eq);

    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
        for (genvar r = 0; r < 2; r++) begin : g_role
            logic [MAX_LEN-1:0] want;
            logic [MAX_LEN-1:0] sfx [IDX_W+1];
            logic [MAX_LEN-1:0] sel;

            for (genvar i = 0; i < MAX_LEN; i++) begin : g_want
                assign want[i] = in_use[i] && (i_entry[i].slot == SLOT_W'(s))
                    && (i_entry[i].role == ((r == 0) ? ROLE_LOW : ROLE_HIGH));
            end

            // suffix or, so the highest feeding entry wins
            assign sfx[0] = want;
            for (genvar b = 0; b < IDX_W; b++) begin : g_sfx
                assign sfx[b+1] = sfx[b] | (sfx[b] >> (1 << b));
            end
            assign sel = want & ~(sfx[IDX_W] >> 1);

            always_comb begin
                pick[s][r] = '0;
                for (int i = 0; i < MAX_LEN; i++) begin
                    pick[s][r] = pick[s][r] | (sel[i] ? o_aligned[i] : '0);
                end
            end
        end
        assign o_capture[s] = {pick[s][1], pick[s][0]};
    end

endmodule

FILE: hw/rtl/wildcard_byte_pattern_search.sv
// wildcard_byte_pattern_search: top level, cell chain, check stage and result buffer
// depends on wbps_pkg, wbps_in_if, wbps_out_if, wbps_cell and wbps_match
//
// usage:
//   i_item carries pattern loads (func 0) and image bytes (func 1); o_result carries
//   match reports and end-of-image summaries; the config port writes pattern_length,
//   anchored, anchor_address and image_origin; the user writes them only while the
//   block is idle, which the block itself does not enforce
//   a pattern load takes effect at the edge that accepts it; an image byte is checked
//   in the cycle after it is accepted, and its results reach o_result via the buffer
//   sustained rate is one item per cycle while o_result is ready; an image byte that
//   gives both a match and a summary stalls the next byte at the two-entry buffer
//   the compare covers all pattern cells at once through a barrel alignment of the
//   window, so the window length does not change the rate
//   when o_result stalls, the buffer keeps up to two results and the check stage
//   holds one byte, then i_item.ready drops; nothing is lost
//   reset (synchronous, active low) restores the register defaults and clears the
//   byte count and hit history; pattern entries hold garbage until loaded
`timescale 1ns / 1ps

module wildcard_byte_pattern_search import wbps_pkg::*; #(
    parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
    parameter int CAPTURE_SLOTS   = DEF_CAPTURE_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wbps_in_if.sink               i_item,
    wbps_out_if.source            o_result
);

    localparam int IDX_W = $clog2(MAX_PATTERN_LEN);

    // configuration
    logic [LEN_W-1:0]  r_pattern_length;
    logic              r_anchored;
    logic [ADDR_W-1:0] r_anchor_address;
    logic [ADDR_W-1:0] r_image_origin;

    // image state
    logic [COUNT_W-1:0] r_bytes_seen;
    logic               r_hit_seen;
    logic               r_multiple_seen;
    logic [ADDR_W-1:0]  r_last_match;

    // check stage
    logic              r_s1_valid;
    logic              r_s1_check;
    logic              r_s1_end;
    logic [ADDR_W-1:0] r_s1_start;
    logic [IDX_W-1:0]  r_s1_shift;

    // result buffer
    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_q_cnt;

    logic               in_fire;
    logic               byte_fire;
    logic               out_pop;
    logic               s1_adv;
    t_cell_ctl          cell_ctl;
    logic               have_room;
    logic [COUNT_W-1:0] cnt_now;
    logic               len_ok;
    logic [ADDR_W-1:0]  start_addr;
    logic               anchor_ok;
    logic [IDX_W-1:0]   shift_amt;

    logic [BYTE_W-1:0]        win_byte [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0]        aligned  [MAX_PATTERN_LEN];
    t_entry                   entry    [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] cell_eq;
    logic                     match_hit;
    logic [WORD_W-1:0]        match_cap [CAPTURE_SLOTS];
    logic [NUM_CAPTURE_WORDS-1:0][WORD_W-1:0] cap_full;

    logic       hit;
    t_result    match_res;
    t_result    sum_res;
    logic [1:0] n_res;

    assign in_fire   = i_item.valid && i_item.ready;
    assign byte_fire = in_fire && (i_item.func == FUNC_BYTE);
    assign out_pop   = o_result.valid && o_result.ready;

    // the check stage moves on only into an empty or emptying buffer: two results always fit
    assign s1_adv = r_s1_valid && ((r_q_cnt == 2'd0) || ((r_q_cnt == 2'd1) && out_pop));
    assign i_item.ready = !r_s1_valid || s1_adv;

    always_comb begin
        cell_ctl.shift            = byte_fire;
        cell_ctl.load             = in_fire && (i_item.func == FUNC_LOAD);
        cell_ctl.load_index       = i_item.entry_index;
        cell_ctl.load_entry.slot  = i_item.capture_slot;
        cell_ctl.load_entry.role  = i_item.capture_role;
        cell_ctl.load_entry.wild  = i_item.entry_wildcard;
        cell_ctl.load_entry.value = i_item.entry_value;
    end

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
        wbps_cell #(
            .POS (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_byte    ((k == 0) ? i_item.image_byte : win_byte[(k == 0) ? 0 : k-1]),
            .i_aligned (aligned[k]),
            .o_byte    (win_byte[k]),
            .o_entry   (entry[k]),
            .o_eq      (cell_eq[k])
        );
    end

    wbps_match #(
        .MAX_LEN (MAX_PATTERN_LEN),
        .SLOTS   (CAPTURE_SLOTS)
    ) u_match (
        .i_window  (win_byte),
        .i_entry   (entry),
        .i_eq      (cell_eq),
        .i_shift   (r_s1_shift),
        .o_aligned (aligned),
        .o_hit     (match_hit),
        .o_capture (match_cap)
    );

    for (genvar s = 0; s < NUM_CAPTURE_WORDS; s++) begin : g_cap
        if (s < CAPTURE_SLOTS) begin : g_used
            assign cap_full[s] = match_cap[s];
        end else begin : g_unused
            assign cap_full[s] = '0;
        end
    end

    // window bookkeeping for the byte being accepted
    always_comb begin
        have_room  = r_bytes_seen != COUNT_MAX;
        cnt_now    = have_room ? (r_bytes_seen + COUNT_W'(1)) : r_bytes_seen;
        len_ok     = (r_pattern_length != '0)
                  && (32'(r_pattern_length) <= MAX_PATTERN_LEN)
                  && (cnt_now >= COUNT_W'(r_pattern_length));
        start_addr = r_image_origin + cnt_now[ADDR_W-1:0] - ADDR_W'(r_pattern_length);
        anchor_ok  = !r_anchored
                  || ((r_anchor_address != NO_ANCHOR) && (start_addr == r_anchor_address));
        shift_amt  = IDX_W'(MAX_PATTERN_LEN - 32'(r_pattern_length));
    end

    always_comb begin
        hit = r_s1_check && match_hit;

        match_res.kind          = KIND_MATCH;
        match_res.match_address = r_s1_start;
        match_res.capture_word  = cap_full;
        match_res.any_hit       = 1'b0;
        match_res.multiple_hits = 1'b0;
        match_res.last_result   = !r_s1_end;

        sum_res.kind            = KIND_SUMMARY;
        sum_res.match_address   = hit ? r_s1_start : r_last_match;
        sum_res.capture_word    = '0;
        sum_res.any_hit         = r_hit_seen || hit;
        sum_res.multiple_hits   = r_multiple_seen || (hit && r_hit_seen);
        sum_res.last_result     = 1'b1;

        n_res = {1'b0, hit} + {1'b0, r_s1_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_anchored       <= 1'b0;
            r_anchor_address <= NO_ANCHOR;
            r_image_origin   <= ORIGIN_RESET;
            r_bytes_seen     <= '0;
            r_hit_seen       <= 1'b0;
            r_multiple_seen  <= 1'b0;
            r_last_match     <= '0;
            r_s1_valid       <= 1'b0;
            r_q_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                    CFG_ANCHORED:       r_anchored       <= i_cfg_data[0];
                    CFG_ANCHOR_ADDRESS: r_anchor_address <= i_cfg_data[ADDR_W-1:0];
                    CFG_IMAGE_ORIGIN:   r_image_origin   <= i_cfg_data[ADDR_W-1:0];
                endcase
            end

            if (byte_fire) begin
                r_bytes_seen <= i_item.image_end ? '0 : cnt_now;
            end

            if (i_item.ready) begin
                r_s1_valid <= byte_fire;
            end

            if (s1_adv) begin
                if (r_s1_end) begin
                    r_hit_seen      <= 1'b0;
                    r_multiple_seen <= 1'b0;
                    r_last_match    <= '0;
                end else if (hit) begin
                    r_hit_seen      <= 1'b1;
                    r_multiple_seen <= r_multiple_seen || r_hit_seen;
                    r_last_match    <= r_s1_start;
                end
                r_q_cnt <= n_res;
            end else if (out_pop) begin
                r_q_cnt <= r_q_cnt - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (byte_fire) begin
            r_s1_check <= have_room && len_ok && anchor_ok;
            r_s1_end   <= i_item.image_end;
            r_s1_start <= start_addr;
            r_s1_shift <= shift_amt;
        end
        if (s1_adv) begin
            r_q0 <= hit ? match_res : sum_res;
            r_q1 <= sum_res;
        end else if (out_pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_result.valid         = r_q_cnt != 2'd0;
    assign o_result.kind          = r_q0.kind;
    assign o_result.match_address = r_q0.match_address;
    assign o_result.capture_word0 = r_q0.capture_word[0];
    assign o_result.capture_word1 = r_q0.capture_word[1];
    assign o_result.capture_word2 = r_q0.capture_word[2];
    assign o_result.capture_word3 = r_q0.capture_word[3];
    assign o_result.any_hit       = r_q0.any_hit;
    assign o_result.multiple_hits = r_q0.multiple_hits;
    assign o_result.last_result   = r_q0.last_result;

endmodule
